>>> hw/rtl/nearest_neighbor_velocity_estimator_core_assert.svh
// Assertion macros for the velocity estimator core.
`ifndef NEAREST_NEIGHBOR_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH
// implication checked every edge outside reset
`define NNV_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define NNV_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/nnve_pkg.sv
// Shared types and constants for the velocity estimator.
`timescale 1ns / 1ps
package nnve_pkg;
  localparam int MaxPeds = 64;
  localparam int IdxW = $clog2(MaxPeds);
  localparam int CntW = $clog2(MaxPeds + 1);
  localparam int AddrW = IdxW + 1;
  localparam int TdataInW = 16 + 24 + 24 + 32;
  localparam int TdataOutW = 16 + 17 + 17 + 6;
  localparam logic [19:0] Million = 20'd1000000;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SRCH  = 13'b0000000000010,
    ST_SWAIT = 13'b0000000000100,
    ST_RDB   = 13'b0000000001000,
    ST_MUL   = 13'b0000000010000,
    ST_DIV   = 13'b0000000100000,
    ST_SHF   = 13'b0000001000000,
    ST_SQ    = 13'b0000010000000,
    ST_SQRT  = 13'b0000100000000,
    ST_SCL   = 13'b0001000000000,
    ST_SDIV  = 13'b0010000000000,
    ST_FIN   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_t;
endpackage

>>> hw/rtl/nearest_neighbor_velocity_estimator_core.sv
// Top level of the nearest-neighbour velocity estimator.
// Each detection is searched against the previous frame. With no previous frame or a zero
// interval the result word follows the search; else two divisions and pre-shifts run, and when
// scaled a 25-step root and two more divisions, all on one divider.
// One word at a time: the next detection is taken only after the result word is accepted; markers
// give no result word. Sync reset clears counts, bank, time, sets cutoff to 1000; RAM is kept.
`timescale 1ns / 1ps
`include "nearest_neighbor_velocity_estimator_core_assert.svh"
module nearest_neighbor_velocity_estimator_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata: ped_id, pos_x, pos_y, frame_time
  input  logic [nnve_pkg::TdataInW-1:0] s_tdata,
  // tuser: op
  input  logic s_tuser,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: out_id, vel_x, vel_y, match_index
  output logic [nnve_pkg::TdataOutW-1:0] m_tdata,
  // tuser: had_previous, bad_interval, overflowed
  output logic [2:0] m_tuser
);
  import nnve_pkg::*;

  state_t state;
  logic [15:0] cutoff;
  logic bank;
  logic [CntW-1:0] prev_count, cur_count;
  logic [31:0] prev_time;

  logic [23:0] mem_x [2*MaxPeds];
  logic [23:0] mem_y [2*MaxPeds];
  logic [AddrW-1:0] rd_addr;
  logic [23:0] rd_x, rd_y;
  logic wr_en;

  logic [15:0] id;
  logic signed [23:0] px, py;
  logic [31:0] dt;
  logic last;
  logic ovf, had, bad;

  logic [CntW-1:0] scan;
  logic rd_vld;
  logic [IdxW-1:0] rd_idx, best;
  logic [48:0] bestd;
  logic signed [24:0] ddy;
  logic nx, ny;

  // shared divider: quotient/remainder of num / den, one bit a cycle
  logic [44:0] num;
  logic [31:0] den;
  logic [32:0] rem;
  logic [5:0] cnt;
  logic comp;
  logic [44:0] ax, ay;
  logic shifted;
  logic [48:0] m2;
  logic [49:0] sq_n;
  logic [49:0] sq_r;
  logic [49:0] sq_b;

  logic [16:0] vx, vy;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[{bank, cur_count[IdxW-1:0]}] <= px;
      mem_y[{bank, cur_count[IdxW-1:0]}] <= py;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  logic signed [24:0] sx, sy;
  logic [49:0] d2;
  assign sx = 25'(px) - 25'(signed'(rd_x));
  assign sy = 25'(py) - 25'(signed'(rd_y));
  assign d2 = 50'(sx * sx) + 50'(sy * sy);

  assign s_tready = (state == ST_IDLE) && !rst;
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {best, vy, vx, id};
  assign m_tuser = {ovf, bad, had};

  logic [33:0] trial;
  assign trial = {rem, num[44]} - {2'b0, den};
  logic [50:0] sq_t;
  assign sq_t = {1'b0, sq_n} - ({1'b0, sq_r} + {1'b0, sq_b});

  always_comb begin
    wr_en = 1'b0;
    rd_addr = {~bank, scan[IdxW-1:0]};
    if (state == ST_SRCH && scan == 0 && cur_count < CntW'(MaxPeds)) wr_en = 1'b1;
    if (state == ST_RDB) rd_addr = {~bank, best};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cutoff <= 16'd1000;
      bank <= 1'b0;
      prev_count <= '0;
      cur_count <= '0;
      prev_time <= '0;
      rd_vld <= 1'b0;
      comp <= 1'b0;
    end else begin
      if (cfg_we) cutoff <= cfg_wdata;
      unique case (state)
        ST_IDLE: if (s_tvalid) begin
          if (s_tuser) begin
            prev_count <= '0;
            cur_count <= '0;
            prev_time <= s_tdata[95:64];
          end else begin
            id <= s_tdata[15:0];
            px <= s_tdata[39:16];
            py <= s_tdata[63:40];
            dt <= s_tdata[95:64] - prev_time;
            last <= s_tlast;
            had <= prev_count != 0;
            bad <= 1'b0;
            best <= '0;
            vx <= '0;
            vy <= '0;
            scan <= '0;
            rd_vld <= 1'b0;
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (scan == 0) begin
            ovf <= !(cur_count < CntW'(MaxPeds));
            if (cur_count < CntW'(MaxPeds)) cur_count <= cur_count + 1'b1;
          end
          rd_vld <= scan < prev_count;
          rd_idx <= scan[IdxW-1:0];
          if (rd_vld) begin
            if (rd_idx == 0 || d2[48:0] < bestd) begin
              bestd <= d2[48:0];
              best <= rd_idx;
            end
          end
          if (scan >= prev_count) state <= ST_SWAIT;
          else scan <= scan + 1'b1;
        end
        ST_SWAIT: begin
          rd_vld <= 1'b0;
          if (rd_vld && (rd_idx == 0 || d2[48:0] < bestd)) begin
            bestd <= d2[48:0];
            best <= rd_idx;
          end
          if (!had) state <= ST_FIN;
          else if (dt == 0) begin
            bad <= 1'b1;
            state <= ST_FIN;
          end else state <= ST_RDB;
        end
        ST_RDB: state <= ST_MUL;
        ST_MUL: begin
          ddy <= sy;
          nx <= sx[24];
          ny <= sy[24];
          comp <= 1'b0;
          num <= 45'(sx[24] ? -sx : sx) * 45'(Million) + 45'(dt >> 1);
          den <= dt;
          rem <= '0;
          cnt <= 6'd45;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == 1 && !comp) begin
            ax <= {num[43:0], ~trial[33]};
            comp <= 1'b1;
            num <= 45'(ddy[24] ? -ddy : ddy) * 45'(Million) + 45'(dt >> 1);
            rem <= '0;
            cnt <= 6'd45;
          end else begin
            if (trial[33]) rem <= {rem[31:0], num[44]};
            else rem <= trial[32:0];
            num <= {num[43:0], ~trial[33]};
            cnt <= cnt - 1'b1;
            if (cnt == 1) begin
              ay <= {num[43:0], ~trial[33]};
              shifted <= 1'b0;
              state <= ST_SHF;
            end
          end
        end
        ST_SHF: begin
          if (ax[44:24] != 0 || ay[44:24] != 0) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
            shifted <= 1'b1;
          end else begin
            m2 <= 49'(ax[23:0] * ax[23:0]);
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          m2 <= m2 + 49'(ay[23:0] * ay[23:0]);
          sq_n <= 50'(m2 + 49'(ay[23:0] * ay[23:0]));
          sq_r <= '0;
          sq_b <= 50'(1) << 48;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (shifted || m2 > 49'(cutoff * cutoff)) begin
            if (!sq_t[50]) begin
              sq_n <= sq_t[49:0];
              sq_r <= (sq_r >> 1) + sq_b;
            end else sq_r <= sq_r >> 1;
            sq_b <= sq_b >> 2;
            if (sq_b[1:0] != 0 || sq_b == 50'd1) state <= ST_SCL;
          end else begin
            vx <= nx ? -17'(ax) : 17'(ax);
            vy <= ny ? -17'(ay) : 17'(ay);
            state <= ST_FIN;
          end
        end
        ST_SCL: begin
          if (sq_r == 0) state <= ST_FIN;
          else begin
            comp <= 1'b0;
            num <= 45'(ax[23:0] * cutoff) + 45'(sq_r >> 1);
            den <= 32'(sq_r);
            rem <= '0;
            cnt <= 6'd45;
            state <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          if (cnt == 1 && !comp) begin
            ax <= {num[43:0], ~trial[33]};
            comp <= 1'b1;
            num <= 45'(ay[23:0] * cutoff) + 45'(sq_r >> 1);
            rem <= '0;
            cnt <= 6'd45;
          end else begin
            if (trial[33]) rem <= {rem[31:0], num[44]};
            else rem <= trial[32:0];
            num <= {num[43:0], ~trial[33]};
            cnt <= cnt - 1'b1;
            if (cnt == 1) begin
              ay <= {num[43:0], ~trial[33]};
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (comp) begin
            vx <= (ax > 45'(cutoff)) ? (nx ? -17'(cutoff) : 17'(cutoff))
                                     : (nx ? -17'(ax) : 17'(ax));
            vy <= (ay > 45'(cutoff)) ? (ny ? -17'(cutoff) : 17'(cutoff))
                                     : (ny ? -17'(ay) : 17'(ay));
            comp <= 1'b0;
          end
          if (last) begin
            prev_count <= cur_count;
            prev_time <= dt + prev_time;
            cur_count <= '0;
            bank <= ~bank;
          end
          state <= ST_OUT;
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  `NNV_ASSERT_IMP(a_ready_idle, clk, rst, s_tready, !m_tvalid)
  `NNV_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `NNV_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, cur_count <= CntW'(MaxPeds))
  `NNV_ASSERT_IMP(a_nohad_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[55:16] == 0)
endmodule
